// ===== hdl/mst_pkg.sv =====
package mst_pkg;
   localparam int SLOTS = 64;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int ENTRY_W = 32 + 2 + 32;

   localparam logic [2:0] MODE_ADD = 3'd0;
   localparam logic [2:0] MODE_CRASH = 3'd1;
   localparam logic [2:0] MODE_REMOVE = 3'd2;
   localparam logic [2:0] MODE_CONTAINS = 3'd3;
   localparam logic [2:0] MODE_NEXT_MASTER = 3'd4;
   localparam logic [2:0] MODE_NEXT_BACKUP = 3'd5;
   localparam logic [2:0] MODE_BUMP = 3'd6;

   localparam logic [2:0] OUT_DONE = 3'd0;
   localparam logic [2:0] OUT_NO_CHANGE = 3'd1;
   localparam logic [2:0] OUT_INVALID = 3'd2;
   localparam logic [2:0] OUT_FULL = 3'd3;
   localparam logic [2:0] OUT_NONE = 3'd4;

   localparam logic [1:0] STATUS_UP = 2'd0;
   localparam logic [1:0] STATUS_CRASHED = 2'd1;
   localparam logic [1:0] STATUS_DOWN = 2'd2;

   // Priority encoder: lowest set bit, with a found flag in the top bit.
   function automatic logic [SLOT_W:0] first_set(input logic [SLOTS-1:0] v);
      logic [SLOT_W:0] r;
      r = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (v[i]) r = {1'b1, SLOT_W'(i)};
      end
      return r;
   endfunction
endpackage

// ===== hdl/mst_ram.sv =====
module mst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== hdl/membership_slot_table_top.sv =====
// A beat's state is read as the beat is accepted; the result is then evaluated and registered.
// One result beat per item; a remove of an UP member gives two (crashed, then down).
// The controller steps through its accept, evaluate and output states, holds each
// result beat while rsp_stall is high, and takes no new beat until the last result beat of the current item has left.
// Reset (synchronous, active high) clears occupancy, status flags, counts and the
// version at once; generation counters are cleared by per-slot valid bits.
module membership_slot_table_top
   import mst_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_mode,
   input  logic [5:0]        req_slot_index,
   input  logic [31:0]       req_generation,
   input  logic [1:0]        req_service_bits,
   input  logic [31:0]       req_read_speed,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_outcome,
   output logic [5:0]        rsp_out_slot,
   output logic [31:0]       rsp_out_generation,
   output logic [1:0]        rsp_out_services,
   output logic [1:0]        rsp_entry_status,
   output logic [31:0]       rsp_out_read_speed,
   output logic [5:0]        rsp_masters_up,
   output logic [5:0]        rsp_backups_up,
   output logic [31:0]       rsp_list_version,
   output logic              rsp_is_member,
   output logic              rsp_last
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EVAL = 2'd1;
   localparam logic [1:0] ST_OUT = 2'd2;
   localparam logic [1:0] ST_DOWN = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [SLOTS-1:0] used_ff, used_in, crashed_ff, crashed_in, gen_valid_ff, gen_valid_in;
   logic [SLOTS-1:0] master_ff, master_in, backup_ff, backup_in;
   logic [5:0] mcount_ff, mcount_in, bcount_ff, bcount_in;
   logic [31:0] version_ff, version_in;

   logic [2:0] mode_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [5:0] slot_raw_ff;
   logic [31:0] gen_ff, speed_ff;
   logic [1:0] svc_ff;

   logic [2:0] o_outcome_ff, o_outcome_in;
   logic [5:0] o_slot_ff, o_slot_in;
   logic [31:0] o_gen_ff, o_gen_in, o_speed_ff, o_speed_in;
   logic [1:0] o_svc_ff, o_svc_in, o_status_ff, o_status_in;
   logic o_member_ff, o_member_in, o_last_ff, o_last_in;

   // The target slot is picked at accept time so both memories are read as the beat is accepted.
   logic [SLOT_W:0] free_hit, srch_hit;
   logic [SLOTS-1:0] srch_mask;
   logic [SLOT_W-1:0] pick_slot;
   logic accept;

   logic ent_we, ng_we;
   logic [ENTRY_W-1:0] ent_wdata, ent_rdata;
   logic [31:0] ng_wdata, ng_rdata, ng_cur;
   logic [SLOT_W:0] hit_ff;
   logic [31:0] e_gen, e_speed;
   logic [1:0] e_svc;
   logic idv;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      free_hit = first_set(~used_ff & ~SLOTS'(1));
      for (int i = 0; i < SLOTS; i++) begin
         srch_mask[i] = used_ff[i] && !crashed_ff[i] && (i >= int'(req_slot_index)) &&
            ((req_mode == MODE_NEXT_MASTER) ? master_ff[i] : backup_ff[i]);
      end
      srch_hit = first_set(srch_mask);
      unique case (req_mode)
         MODE_ADD: pick_slot = free_hit[SLOT_W-1:0];
         MODE_NEXT_MASTER, MODE_NEXT_BACKUP: pick_slot = srch_hit[SLOT_W-1:0];
         default: pick_slot = SLOT_W'(req_slot_index);
      endcase
   end

   assign {e_gen, e_svc, e_speed} = ent_rdata;
   assign ng_cur = gen_valid_ff[slot_ff] ? ng_rdata : 32'd0;
   assign idv = ({26'd0, slot_raw_ff} < SLOTS) && used_ff[slot_ff] && (e_gen == gen_ff);

   mst_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_entry (
      .clock(clock), .wr_en(ent_we), .wr_addr(slot_ff), .wr_data(ent_wdata),
      .rd_addr(pick_slot), .rd_data(ent_rdata));
   mst_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_next_gen (
      .clock(clock), .wr_en(ng_we), .wr_addr(slot_ff), .wr_data(ng_wdata),
      .rd_addr(pick_slot), .rd_data(ng_rdata));

   always_comb begin
      state_in = state_ff;
      used_in = used_ff; crashed_in = crashed_ff; gen_valid_in = gen_valid_ff;
      master_in = master_ff; backup_in = backup_ff;
      mcount_in = mcount_ff; bcount_in = bcount_ff; version_in = version_ff;
      o_outcome_in = o_outcome_ff; o_slot_in = o_slot_ff; o_gen_in = o_gen_ff;
      o_speed_in = o_speed_ff; o_svc_in = o_svc_ff; o_status_in = o_status_ff;
      o_member_in = o_member_ff; o_last_in = o_last_ff;
      ent_we = 1'b0; ng_we = 1'b0;
      ent_wdata = {ng_cur, svc_ff, svc_ff[1] ? speed_ff : 32'd0};
      ng_wdata = ng_cur + 32'd1;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EVAL;
         ST_EVAL: begin
            state_in = ST_OUT;
            o_outcome_in = OUT_DONE; o_slot_in = '0; o_gen_in = '0; o_svc_in = '0;
            o_status_in = STATUS_UP; o_speed_in = '0; o_member_in = 1'b0; o_last_in = 1'b1;
            case (mode_ff)
               MODE_ADD: begin
                  if (!hit_ff[SLOT_W]) begin
                     o_outcome_in = OUT_FULL;
                  end else begin
                     ent_we = 1'b1; ng_we = 1'b1;
                     used_in[slot_ff] = 1'b1; crashed_in[slot_ff] = 1'b0;
                     gen_valid_in[slot_ff] = 1'b1;
                     master_in[slot_ff] = svc_ff[0]; backup_in[slot_ff] = svc_ff[1];
                     if (svc_ff[0]) mcount_in = mcount_ff + 6'd1;
                     if (svc_ff[1]) bcount_in = bcount_ff + 6'd1;
                     o_slot_in = 6'(slot_ff); o_gen_in = ng_cur; o_svc_in = svc_ff;
                     o_speed_in = svc_ff[1] ? speed_ff : 32'd0;
                  end
               end
               MODE_CRASH, MODE_REMOVE: begin
                  if (!idv) begin
                     o_outcome_in = OUT_INVALID; o_slot_in = slot_raw_ff; o_gen_in = gen_ff;
                  end else begin
                     o_slot_in = slot_raw_ff; o_gen_in = gen_ff; o_svc_in = e_svc;
                     o_speed_in = e_svc[1] ? e_speed : 32'd0;
                     o_status_in = STATUS_CRASHED;
                     if (crashed_ff[slot_ff]) begin
                        if (mode_ff == MODE_CRASH) o_outcome_in = OUT_NO_CHANGE;
                        else begin
                           o_status_in = STATUS_DOWN; used_in[slot_ff] = 1'b0;
                        end
                     end else begin
                        crashed_in[slot_ff] = 1'b1;
                        if (e_svc[0]) mcount_in = mcount_ff - 6'd1;
                        if (e_svc[1]) bcount_in = bcount_ff - 6'd1;
                        if (mode_ff == MODE_REMOVE) o_last_in = 1'b0;
                     end
                  end
               end
               MODE_CONTAINS: begin
                  o_slot_in = slot_raw_ff; o_gen_in = gen_ff; o_member_in = idv;
               end
               MODE_NEXT_MASTER, MODE_NEXT_BACKUP: begin
                  if (!hit_ff[SLOT_W]) o_outcome_in = OUT_NONE;
                  else begin
                     o_slot_in = 6'(slot_ff); o_gen_in = e_gen; o_svc_in = e_svc;
                     o_speed_in = e_svc[1] ? e_speed : 32'd0;
                  end
               end
               MODE_BUMP: version_in = version_ff + 32'd1;
               default: o_outcome_in = OUT_NO_CHANGE;
            endcase
         end
         ST_OUT: if (!rsp_stall) begin
            if (!o_last_ff) begin
               state_in = ST_DOWN;
               used_in[slot_ff] = 1'b0;
               o_status_in = STATUS_DOWN; o_last_in = 1'b1;
            end else state_in = ST_IDLE;
         end
         ST_DOWN: if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff <= '0; crashed_ff <= '0; gen_valid_ff <= '0;
         master_ff <= '0; backup_ff <= '0;
         mcount_ff <= '0; bcount_ff <= '0; version_ff <= '0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in; crashed_ff <= crashed_in; gen_valid_ff <= gen_valid_in;
         master_ff <= master_in; backup_ff <= backup_in;
         mcount_ff <= mcount_in; bcount_ff <= bcount_in; version_ff <= version_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode; slot_ff <= pick_slot; slot_raw_ff <= req_slot_index;
         gen_ff <= req_generation; speed_ff <= req_read_speed; svc_ff <= req_service_bits;
         hit_ff <= (req_mode == MODE_ADD) ? free_hit : srch_hit;
      end
      o_outcome_ff <= o_outcome_in; o_slot_ff <= o_slot_in; o_gen_ff <= o_gen_in;
      o_speed_ff <= o_speed_in; o_svc_ff <= o_svc_in; o_status_ff <= o_status_in;
      o_member_ff <= o_member_in; o_last_ff <= o_last_in;
   end

   assign rsp_valid = (state_ff == ST_OUT) || (state_ff == ST_DOWN);
   assign rsp_outcome = o_outcome_ff;
   assign rsp_out_slot = o_slot_ff;
   assign rsp_out_generation = o_gen_ff;
   assign rsp_out_services = o_svc_ff;
   assign rsp_entry_status = o_status_ff;
   assign rsp_out_read_speed = o_speed_ff;
   assign rsp_masters_up = mcount_ff;
   assign rsp_backups_up = bcount_ff;
   assign rsp_list_version = version_ff;
   assign rsp_is_member = o_member_ff;
   assign rsp_last = o_last_ff;
endmodule
